>>> hw/rtl/skf_pkg.sv
// ----------------------------------------------------------------------------
// skf_pkg
// Types and constants shared by the scalar Kalman filter modules.
// ----------------------------------------------------------------------------
`default_nettype none

package skf_pkg;

	localparam int unsigned CH_W       = 4;
	localparam int unsigned CH_CODES   = 1 << CH_W;
	localparam int unsigned COV_W      = 31;
	localparam int unsigned EST_W      = 32;
	localparam int unsigned GAIN_W     = 17;
	localparam int unsigned DIV_STEPS  = 17;
	localparam int unsigned DIV_CNT_W  = 5;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 32;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_PROCESS_NOISE      = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SENSOR_NOISE       = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_INITIAL_COVARIANCE = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_INITIAL_ESTIMATE   = 2'd3;

	// reset values, Q16.16
	localparam logic [COV_W-1:0] PROCESS_NOISE_RST = 31'd8192;
	localparam logic [COV_W-1:0] SENSOR_NOISE_RST  = 31'd20972;
	localparam logic [COV_W-1:0] COV_RST           = 31'd1966080;
	localparam logic [EST_W-1:0] EST_RST           = 32'd0;

	// gain of 1.0 in Q1.16
	localparam logic [GAIN_W-1:0] GAIN_ONE = 17'h10000;

	typedef struct packed {
		logic [CH_W-1:0]         channel;
		logic signed [EST_W-1:0] measurement;
		logic                    restart;
	} meas_t;

	typedef struct packed {
		logic [CH_W-1:0]         channel_out;
		logic signed [EST_W-1:0] estimate;
	} est_t;

	typedef struct packed {
		logic accept;
		logic load;
		logic init;
		logic step;
		logic mul;
		logic finish;
	} skf_cmd_t;

	typedef struct packed {
		logic div_last;
	} skf_sts_t;

endpackage

`default_nettype wire

>>> hw/rtl/skf_ram.sv
// ----------------------------------------------------------------------------
// skf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module skf_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16,
	localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [WIDTH-1:0]  wdata,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic      [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

>>> hw/rtl/skf_datapath.sv
// ----------------------------------------------------------------------------
// skf_datapath
// Per-channel state RAM, config registers, time update, radix-2 gain divider,
// measurement update multipliers and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module skf_datapath
	import skf_pkg::*;
#(
	parameter int unsigned CHANNELS = 16,
	localparam int unsigned SLOT_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire meas_t                 meas,
	input  wire logic                  cfg_write,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire skf_cmd_t              cmd,
	output skf_sts_t                   sts,
	output est_t                       est
);

	localparam int unsigned RAM_W = COV_W + EST_W;

	logic [COV_W-1:0] q_q;
	logic [COV_W-1:0] r_q;
	logic [COV_W-1:0] init_cov_q;
	logic [EST_W-1:0] init_est_q;

	logic [SLOT_W-1:0] slot_lut [CH_CODES];
	logic [SLOT_W-1:0] slot_q;
	logic [CH_W-1:0]   ch_q;
	logic [EST_W-1:0]  z_q;
	logic              restart_q;
	logic [CHANNELS-1:0] valid_q;

	logic [RAM_W-1:0] rd_data;
	logic [RAM_W-1:0] wr_data;

	logic [COV_W-1:0]        p_sel;
	logic [EST_W-1:0]        x_sel;
	logic [COV_W:0]          p_sum;
	logic [COV_W-1:0]        p1_q;
	logic [EST_W-1:0]        x_q;
	logic signed [EST_W:0]   diff_q;
	logic [EST_W-1:0]        den_q;
	logic [EST_W:0]          rem_q;
	logic [EST_W+1:0]        trial;
	logic                    ge;
	logic [EST_W:0]          rem_next;
	logic [GAIN_W-1:0]       k_q;
	logic [DIV_CNT_W-1:0]    cnt_q;
	logic [GAIN_W-1:0]       k_eff;
	logic signed [50:0]      prod_x_q;
	logic [47:0]             prod_p_q;
	logic signed [EST_W+2:0] upd;
	logic [EST_W-1:0]        x1;
	logic [COV_W-1:0]        p_new;

	// channel to store slot, folded at elaboration
	for (genvar g = 0; g < CH_CODES; g++) begin : g_slot
		localparam int unsigned SLOT_G = g % CHANNELS;
		assign slot_lut[g] = SLOT_W'(SLOT_G);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_q        <= PROCESS_NOISE_RST;
			r_q        <= SENSOR_NOISE_RST;
			init_cov_q <= COV_RST;
			init_est_q <= EST_RST;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_PROCESS_NOISE:      q_q        <= cfg_data[COV_W-1:0];
				REG_SENSOR_NOISE:       r_q        <= cfg_data[COV_W-1:0];
				REG_INITIAL_COVARIANCE: init_cov_q <= cfg_data[COV_W-1:0];
				REG_INITIAL_ESTIMATE:   init_est_q <= cfg_data[EST_W-1:0];
				default: ;
			endcase
		end
	end

	skf_ram #(
		.WIDTH (RAM_W),
		.DEPTH (CHANNELS)
	) u_state_ram (
		.clk   (clk),
		.we    (cmd.finish),
		.waddr (slot_q),
		.wdata (wr_data),
		.raddr (slot_lut[meas.channel]),
		.rdata (rd_data)
	);

	// entries never written read as the reset state
	always_comb begin
		if (restart_q) begin
			p_sel = init_cov_q;
			x_sel = init_est_q;
		end else if (valid_q[slot_q]) begin
			p_sel = rd_data[RAM_W-1:EST_W];
			x_sel = rd_data[EST_W-1:0];
		end else begin
			p_sel = COV_RST;
			x_sel = EST_RST;
		end
		p_sum = {1'b0, p_sel} + {1'b0, q_q};
	end

	assign trial    = {1'b0, rem_q} - {2'b00, den_q};
	assign ge       = !trial[EST_W+1];
	assign rem_next = ge ? trial[EST_W:0] : rem_q;
	assign k_eff    = (den_q == '0) ? GAIN_ONE : k_q;
	assign sts.div_last = (cnt_q == DIV_CNT_W'(DIV_STEPS - 1));

	always_comb begin
		upd = {{3{x_q[EST_W-1]}}, x_q} + prod_x_q[50:16];
		if (!upd[EST_W+2] && (upd[EST_W+1:EST_W-1] != 3'b000)) begin
			x1 = {1'b0, {(EST_W-1){1'b1}}};
		end else if (upd[EST_W+2] && (upd[EST_W+1:EST_W-1] != 3'b111)) begin
			x1 = {1'b1, {(EST_W-1){1'b0}}};
		end else begin
			x1 = upd[EST_W-1:0];
		end
		p_new   = prod_p_q[46:16];
		wr_data = {p_new, x1};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (cmd.finish) begin
			valid_q[slot_q] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			ch_q      <= meas.channel;
			z_q       <= meas.measurement;
			restart_q <= meas.restart;
			slot_q    <= slot_lut[meas.channel];
		end
		if (cmd.load) begin
			p1_q <= p_sum[COV_W] ? {COV_W{1'b1}} : p_sum[COV_W-1:0];
			x_q  <= x_sel;
		end
		if (cmd.init) begin
			den_q  <= {1'b0, p1_q} + {1'b0, r_q};
			rem_q  <= {2'b00, p1_q};
			cnt_q  <= '0;
			diff_q <= $signed({z_q[EST_W-1], z_q}) - $signed({x_q[EST_W-1], x_q});
		end
		if (cmd.step) begin
			rem_q <= {rem_next[EST_W-1:0], 1'b0};
			k_q   <= {k_q[GAIN_W-2:0], ge};
			cnt_q <= cnt_q + 1'b1;
		end
		if (cmd.mul) begin
			prod_x_q <= $signed({1'b0, k_eff}) * diff_q;
			prod_p_q <= 48'(GAIN_ONE - k_eff) * 48'(p1_q);
		end
		if (cmd.finish) begin
			est.channel_out <= ch_q;
			est.estimate    <= x1;
		end
	end

endmodule

`default_nettype wire

>>> hw/rtl/skf_ctrl.sv
// ----------------------------------------------------------------------------
// skf_ctrl
// Sequencer for one filter update: handshakes, step commands, result valid.
// ----------------------------------------------------------------------------
`default_nettype none

module skf_ctrl
	import skf_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     meas_valid,
	output logic          meas_stall,
	output logic          est_valid,
	input  wire logic     est_stall,
	input  wire skf_sts_t sts,
	output skf_cmd_t      cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_INIT,
		ST_DIV,
		ST_MUL,
		ST_FINISH
	} state_t;

	state_t state_q;
	logic   busy_q;
	logic   est_valid_q;
	logic   out_free;

	assign meas_stall = busy_q;
	assign est_valid  = est_valid_q;
	assign out_free   = !est_valid_q || !est_stall;

	always_comb begin
		cmd        = '0;
		cmd.accept = (state_q == ST_IDLE) && meas_valid && !busy_q;
		cmd.load   = (state_q == ST_LOAD);
		cmd.init   = (state_q == ST_INIT);
		cmd.step   = (state_q == ST_DIV);
		cmd.mul    = (state_q == ST_MUL);
		cmd.finish = (state_q == ST_FINISH) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			busy_q      <= 1'b0;
			est_valid_q <= 1'b0;
		end else begin
			if (est_valid_q && !est_stall) begin
				est_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (cmd.accept) begin
						state_q <= ST_LOAD;
						busy_q  <= 1'b1;
					end
				end
				ST_LOAD: state_q <= ST_INIT;
				ST_INIT: state_q <= ST_DIV;
				ST_DIV: begin
					if (sts.div_last) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: state_q <= ST_FINISH;
				ST_FINISH: begin
					// wait for the result register to drain
					if (out_free) begin
						state_q     <= ST_IDLE;
						busy_q      <= 1'b0;
						est_valid_q <= 1'b1;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

>>> hw/rtl/scalar_kalman_filter.sv
// Each accepted measurement steps through the load, init, divide, multiply and
// finish states; the result is registered once the output register is free.
// One item is in flight at a time; a 17-step restoring divider forms the gain.
// Reset: config registers return to defaults and every channel reads as
// covariance 30.0 and estimate 0.0 at once through per-channel valid bits.
// ----------------------------------------------------------------------------
// scalar_kalman_filter
// Multi-channel one-dimensional Kalman filter, signed Q16.16.
// ----------------------------------------------------------------------------
`default_nettype none

module scalar_kalman_filter
	import skf_pkg::*;
#(
	parameter int unsigned CHANNELS = 16
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  meas_valid,
	output logic                       meas_stall,
	input  wire meas_t                 meas,
	output logic                       est_valid,
	input  wire logic                  est_stall,
	output est_t                       est,
	input  wire logic                  cfg_write,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	skf_cmd_t cmd;
	skf_sts_t sts;

	skf_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.meas_valid (meas_valid),
		.meas_stall (meas_stall),
		.est_valid  (est_valid),
		.est_stall  (est_stall),
		.sts        (sts),
		.cmd        (cmd)
	);

	skf_datapath #(
		.CHANNELS (CHANNELS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.meas      (meas),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.sts       (sts),
		.est       (est)
	);

`ifndef NO_ASSERTIONS
	// an accepted transaction keeps the input side closed until its result is out
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(meas_valid && !meas_stall) |=> meas_stall)
		else $error("input not stalled after accepted transaction");

	// a result appears only at the end of an update
	a_result_from_update: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(est_valid) |-> $past(meas_stall))
		else $error("result valid without an update in progress");

	// the input side reopens only together with a registered result
	a_release_with_result: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(meas_stall) |-> est_valid)
		else $error("input released without a result");
`endif

endmodule

`default_nettype wire

>>> test/tb_scalar_kalman_filter.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_scalar_kalman_filter
// Self-checking bench for the multi-channel scalar Kalman filter. A class
// keeps its own per-channel covariance and estimate, predicts each filtered
// estimate from the accepted measurements and checks the results in order.
// Directed corner cases come first, then random phases with new register
// settings and varying idle and stall patterns on the input and result sides.
// ----------------------------------------------------------------------------

module tb_scalar_kalman_filter;
	import skf_pkg::*;

	localparam int unsigned RANDOM_PHASES   = 8;
	localparam int unsigned ITEMS_PER_PHASE = 110;
	localparam int unsigned PRESSURE_PHASE  = 4;
	localparam int unsigned HOLD_CYCLES     = 300;
	localparam int unsigned SETTLE_CYCLES   = 4;
	localparam int unsigned TAIL_CYCLES     = 30;
	localparam int unsigned WATCHDOG_LIMIT  = 3000;

	typedef enum logic [1:0] {
		IDLE_NONE,
		IDLE_SENDER,
		IDLE_RECEIVER,
		IDLE_BOTH
	} idle_mode_e;

	class kalman_scoreboard;
		logic [COV_W-1:0]        noise_q;
		logic [COV_W-1:0]        noise_r;
		logic [COV_W-1:0]        cov_init;
		logic signed [EST_W-1:0] est_init;
		logic [COV_W-1:0]        covariance [CH_CODES];
		logic signed [EST_W-1:0] estimate   [CH_CODES];
		est_t                    pending_estimates [$];
		int                      failures;

		function new();
			noise_q  = PROCESS_NOISE_RST;
			noise_r  = SENSOR_NOISE_RST;
			cov_init = COV_RST;
			est_init = EST_RST;
			failures = 0;
			for (int i = 0; i < CH_CODES; i++) begin
				covariance[i] = COV_RST;
				estimate[i]   = EST_RST;
			end
		endfunction

		function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			// bit 31 of the variance registers is dropped
			case (idx)
				REG_PROCESS_NOISE:      noise_q  = data[COV_W-1:0];
				REG_SENSOR_NOISE:       noise_r  = data[COV_W-1:0];
				REG_INITIAL_COVARIANCE: cov_init = data[COV_W-1:0];
				REG_INITIAL_ESTIMATE:   est_init = data;
				default: ;
			endcase
		endfunction

		function void note_measurement(meas_t m);
			logic [CH_W-1:0]   slot;
			longint unsigned   p1;
			longint unsigned   den;
			longint unsigned   gain;
			longint            diff;
			longint            x1;
			est_t              res;

			slot = m.channel;
			if (m.restart) begin
				covariance[slot] = cov_init;
				estimate[slot]   = est_init;
			end
			p1 = 64'(covariance[slot]) + 64'(noise_q);
			if (p1 > 64'h7FFF_FFFF)
				p1 = 64'h7FFF_FFFF;
			den = p1 + 64'(noise_r);
			// gain in Q1.16, exactly 1.0 when the denominator vanishes
			gain = (den == 0) ? 64'd65536 : (p1 << 16) / den;
			diff = longint'($signed(m.measurement)) - longint'(estimate[slot]);
			x1 = longint'(estimate[slot]) + ((longint'(gain) * diff) >>> 16);
			if (x1 > 64'sh7FFF_FFFF)
				x1 = 64'sh7FFF_FFFF;
			if (x1 < -64'sh8000_0000)
				x1 = -64'sh8000_0000;
			covariance[slot] = COV_W'(((64'd65536 - gain) * p1) >> 16);
			estimate[slot]   = x1[EST_W-1:0];
			res.channel_out  = m.channel;
			res.estimate     = x1[EST_W-1:0];
			pending_estimates.push_back(res);
		endfunction

		function void check_estimate(est_t got);
			est_t want;

			if (pending_estimates.size() == 0) begin
				$error("unexpected estimate transaction: channel_out %0d, estimate %0d",
					got.channel_out, $signed(got.estimate));
				failures++;
				return;
			end
			want = pending_estimates.pop_front();
			if (got.channel_out !== want.channel_out) begin
				$error("channel_out mismatch: expected %0d, actual %0d",
					want.channel_out, got.channel_out);
				failures++;
			end
			if (got.estimate !== want.estimate) begin
				$error("estimate mismatch: expected %0d, actual %0d",
					$signed(want.estimate), $signed(got.estimate));
				failures++;
			end
		endfunction

		function int outstanding();
			return pending_estimates.size();
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  meas_valid = 1'b0;
	logic                  meas_stall;
	meas_t                 meas = '0;
	logic                  est_valid;
	logic                  est_stall = 1'b0;
	est_t                  est;
	logic                  cfg_write = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	idle_mode_e       idle_mode = IDLE_NONE;
	logic             hold_request = 1'b0;
	logic             hold_done = 1'b0;
	int unsigned      quiet_cycles = 0;
	kalman_scoreboard sb = new();

	scalar_kalman_filter uut (
		.clk(clk),
		.arst_n(arst_n),
		.meas_valid(meas_valid),
		.meas_stall(meas_stall),
		.meas(meas),
		.est_valid(est_valid),
		.est_stall(est_stall),
		.est(est),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// transaction monitor and watchdog
	always @(posedge clk) begin
		if (meas_valid && !meas_stall)
			sb.note_measurement(meas);
		if (est_valid && !est_stall)
			sb.check_estimate(est);
		if ((meas_valid && !meas_stall) || (est_valid && !est_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == WATCHDOG_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// result side: random stalls, plus one long hold-off on request
	initial begin
		forever begin
			@(posedge clk);
			if (hold_request && !hold_done) begin
				hold_done <= 1'b1;
				est_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			case (idle_mode)
				IDLE_RECEIVER: est_stall <= ($urandom_range(0, 99) < 62);
				IDLE_BOTH:     est_stall <= ($urandom_range(0, 99) < 17);
				default:       est_stall <= 1'b0;
			endcase
		end
	end

	function automatic logic sender_idles();
		case (idle_mode)
			IDLE_SENDER: return $urandom_range(0, 99) < 62;
			IDLE_BOTH:   return $urandom_range(0, 99) < 17;
			default:     return 1'b0;
		endcase
	endfunction

	function automatic logic [CFG_DATA_W-1:0] small_signed();
		return CFG_DATA_W'($urandom_range(0, 32'h0040_0000)) - 32'h0020_0000;
	endfunction

	function automatic logic [CFG_DATA_W-1:0] pick_variance();
		case ($urandom_range(0, 5))
			0:       return '0;
			1:       return $urandom;
			default: return CFG_DATA_W'($urandom_range(0, 32'h0010_0000));
		endcase
	endfunction

	function automatic meas_t make_meas(int unsigned ch, logic [EST_W-1:0] z, logic rs);
		meas_t m;

		m.channel     = CH_W'(ch);
		m.measurement = z;
		m.restart     = rs;
		return m;
	endfunction

	function automatic meas_t random_meas();
		return make_meas($urandom_range(0, CH_CODES - 1),
			($urandom_range(0, 3) == 0) ? $urandom : small_signed(),
			$urandom_range(0, 7) == 0);
	endfunction

	task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		sb.set_register(idx, data);
	endtask

	// only called while nothing is in flight
	task automatic program_filter(logic [CFG_DATA_W-1:0] q, logic [CFG_DATA_W-1:0] r,
		logic [CFG_DATA_W-1:0] p0, logic [CFG_DATA_W-1:0] x0);
		write_register(REG_PROCESS_NOISE, q);
		write_register(REG_SENSOR_NOISE, r);
		write_register(REG_INITIAL_COVARIANCE, p0);
		write_register(REG_INITIAL_ESTIMATE, x0);
		cfg_write <= 1'b0;
	endtask

	task automatic send_measurement(meas_t m);
		int unsigned gap;

		gap = 0;
		if (idle_mode != IDLE_NONE && $urandom_range(0, 15) == 0)
			gap = $urandom_range(1, 40);
		while (sender_idles())
			gap++;
		if (gap != 0) begin
			meas_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		meas_valid <= 1'b1;
		meas <= m;
		do @(posedge clk); while (meas_stall);
	endtask

	task automatic wait_drained();
		meas_valid <= 1'b0;
		// let the monitor note the last accepted transaction first
		@(posedge clk);
		while (sb.outstanding() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings and reset channel state, field extremes
		send_measurement(make_meas(0, 32'h0000_0000, 1'b0));
		send_measurement(make_meas(15, 32'h7FFF_FFFF, 1'b0));
		send_measurement(make_meas(1, 32'h8000_0000, 1'b0));
		send_measurement(make_meas(0, 32'hFFFF_FFFF, 1'b1));
		send_measurement(make_meas(2, 32'h0001_0000, 1'b1));
		send_measurement(make_meas(15, 32'h8000_0000, 1'b0));
		wait_drained();

		// all zero: zero denominator, gain of one
		program_filter('0, '0, '0, '0);
		send_measurement(make_meas(3, 32'h0000_3039, 1'b1));
		send_measurement(make_meas(3, 32'h8000_0000, 1'b0));
		send_measurement(make_meas(3, 32'h7FFF_FFFF, 1'b0));
		wait_drained();

		// all ones: unused top bits, covariance saturation, largest estimate
		program_filter('1, '1, '1, 32'h7FFF_FFFF);
		send_measurement(make_meas(4, 32'h8000_0000, 1'b1));
		send_measurement(make_meas(4, 32'h7FFF_FFFF, 1'b0));
		send_measurement(make_meas(4, 32'h8000_0000, 1'b0));
		wait_drained();

		program_filter(32'h7FFF_FFFF, '0, 32'h7FFF_FFFF, 32'h8000_0000);
		send_measurement(make_meas(5, 32'h7FFF_FFFF, 1'b1));
		send_measurement(make_meas(15, 32'h8000_0000, 1'b1));
		send_measurement(make_meas(15, 32'h7FFF_FFFF, 1'b0));
		send_measurement(make_meas(5, 32'h0000_0000, 1'b0));
		wait_drained();

		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			program_filter(pick_variance(), pick_variance(), pick_variance(),
				($urandom_range(0, 2) == 0) ? $urandom : small_signed());
			idle_mode = idle_mode_e'(ph % 4);
			// receiver holds off while the sender keeps offering
			if (ph == PRESSURE_PHASE)
				hold_request <= 1'b1;
			repeat (ITEMS_PER_PHASE) send_measurement(random_meas());
			wait_drained();
		end

		repeat (TAIL_CYCLES) @(posedge clk);
		if (sb.failures == 0 && sb.outstanding() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
